// ===== design/sbe_pkg.sv =====
// Package for the market message decoder: payload structs, phase and tag codes.
// No dependencies.
`default_nettype none
package sbe_pkg;

  localparam logic [15:0] BestQuoteTidReset = 16'd20000;
  localparam logic [15:0] BookTidReset      = 16'd20001;
  localparam logic [15:0] TradeTidReset     = 16'd20002;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_BEST_QUOTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOOK       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRADE      = 2'd2;
  localparam int unsigned DefaultQueueDepth = 4;

  localparam logic [15:0] BestQuoteKnownBlock  = 16'd98;
  localparam logic [15:0] BookKnownBlock       = 16'd35;
  localparam logic [15:0] TradeKnownBlock      = 16'd10;
  localparam logic [15:0] LevelKnownBlock      = 16'd16;
  localparam logic [15:0] TradeEntryKnownBlock = 16'd35;

  localparam logic [5:0] PH_H_BL = 6'd0, PH_H_TID = 6'd1, PH_H_SCH = 6'd2, PH_H_VER = 6'd3;
  localparam logic [5:0] PH_EXEC_CHARS = 6'd30, PH_SYM_CHARS = 6'd31, PH_ROOT_SKIP = 6'd32;
  localparam logic [5:0] PH_ASK_BLEN = 6'd33, PH_ASK_CNT = 6'd34, PH_BID_BLEN = 6'd35;
  localparam logic [5:0] PH_BID_CNT = 6'd36, PH_TRD_BLEN = 6'd37, PH_TRD_CNT = 6'd38;
  localparam logic [5:0] PH_ASK_SKIP = 6'd39, PH_BID_SKIP = 6'd40, PH_TRD_SKIP = 6'd41;
  localparam logic [5:0] PH_EXEC_LEN = 6'd42, PH_SYM_LEN = 6'd43, PH_DONE = 6'd44;
  localparam logic [5:0] PH_BODY_FIRST = 6'd4, PH_PEXP = 6'd16, PH_SEXP = 6'd17;
  localparam logic [5:0] PH_PKG = 6'd18, PH_ASK_PX = 6'd19, PH_ASK_SZ = 6'd20;
  localparam logic [5:0] PH_BID_PX = 6'd21, PH_BID_SZ = 6'd22, PH_FILL = 6'd23;
  localparam logic [5:0] PH_TRD_SEQ = 6'd26, PH_SIDE = 6'd27;
  localparam logic [5:0] PH_UPD = 6'd7, PH_BLOCK_FLAG = 6'd28, PH_RPI = 6'd29;

  localparam logic [5:0] TAG_EXEC_CHAR = 6'd30, TAG_SYM_CHAR = 6'd31;
  localparam logic [5:0] TAG_ASK_COUNT = 6'd32, TAG_BID_COUNT = 6'd33;
  localparam logic [5:0] TAG_TRADE_COUNT = 6'd34, TAG_END = 6'd35, TAG_ERROR = 6'd36;

  localparam logic [1:0] KIND_NONE = 2'd0, KIND_QUOTE = 2'd1, KIND_BOOK = 2'd2;
  localparam logic [1:0] KIND_TRADE = 2'd3;
  localparam logic [1:0] ERR_NONE = 2'd0, ERR_TRUNC = 2'd1, ERR_SHORT = 2'd2;
  localparam logic [1:0] ERR_TEMPLATE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } sbe_in_t;

  typedef struct packed {
    logic [5:0]         field_tag;
    logic signed [63:0] field_value;
    logic [15:0]        entry_number;
    logic [1:0]         message_kind;
    logic [1:0]         error_code;
    logic               last_of_run;
  } sbe_out_t;

  // What the front hands to the back: up to two results caused by one byte.
  typedef struct packed {
    logic     two;
    sbe_out_t first;
    sbe_out_t second;
  } sbe_pair_t;

  typedef struct packed {
    logic [15:0] best_quote;
    logic [15:0] book;
    logic [15:0] trade;
  } sbe_cfg_t;

endpackage
`default_nettype wire

// ===== design/sbe_parser.sv =====
// Front part: byte-serial parser state machine; emits result pairs per byte.
// Depends on sbe_pkg.
`default_nettype none
module sbe_parser import sbe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire sbe_in_t   in_i,
  input  wire sbe_cfg_t  cfg_i,
  output logic           pair_valid_o,
  output sbe_pair_t      pair_o
);

  logic [5:0]  ph_q, ph_d;
  logic [63:0] acc_q, acc_d;
  logic [2:0]  bif_q, bif_d;
  logic [15:0] rbl_q, rbl_d, gel_q, gel_d, gec_q, gec_d, eix_q, eix_d, bib_q, bib_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  sbl_q, sbl_d;
  logic        disc_q, disc_d;

  sbe_out_t r [2];
  logic [1:0] n;
  logic       err;

  function automatic logic [3:0] fsize(input logic [5:0] p);
    if (p <= PH_H_VER) return 4'd2;
    if (p >= PH_PEXP && p <= PH_PKG) return 4'd1;
    if (p >= PH_SIDE && p <= PH_RPI) return 4'd1;
    if (p >= PH_BODY_FIRST && p <= PH_TRD_SEQ) return 4'd8;
    if (p >= PH_ASK_BLEN && p <= PH_TRD_CNT) return 4'd2;
    return 4'd1;
  endfunction

  always_comb begin
    logic [5:0]  ph;
    logic [63:0] v, val, accn;
    logic [2:0]  bifn;
    logic [1:0]  k;
    logic [15:0] eixn, known;
    logic        done;
    ph = ph_q; ph_d = ph_q; acc_d = acc_q; bif_d = bif_q; rbl_d = rbl_q; gel_d = gel_q;
    gec_d = gec_q; eix_d = eix_q; bib_d = bib_q; kind_d = kind_q; sbl_d = sbl_q;
    disc_d = disc_q;
    r[0] = '0; r[1] = '0; n = 2'd0; err = 1'b0;
    v = '0; val = '0; k = KIND_NONE; eixn = eix_q + 16'd1; known = '0;
    accn = acc_q | (64'(in_i.data_byte) << {bif_q, 3'b000});
    bifn = bif_q + 3'd1;
    done = (bifn == 3'd0) || ({1'b0, bifn} >= fsize(ph));
    if (valid_i) begin
      if (!disc_q && ph != PH_DONE) begin
        if ((ph >= PH_BODY_FIRST && ph <= PH_RPI) || ph == PH_ROOT_SKIP ||
            (ph >= PH_ASK_SKIP && ph <= PH_TRD_SKIP)) begin
          bib_d = bib_q + 16'd1;
        end
        if (ph == PH_ROOT_SKIP) begin
          if (bib_d >= rbl_q) begin
            ph_d = (kind_q == KIND_QUOTE) ? PH_SYM_LEN :
                   (kind_q == KIND_BOOK) ? PH_ASK_BLEN : PH_TRD_BLEN;
          end
        end else if (ph == PH_ASK_SKIP || ph == PH_BID_SKIP) begin
          if (bib_d >= gel_q) begin
            eix_d = eixn;
            if (eixn == gec_q) ph_d = (ph == PH_BID_SKIP) ? PH_SYM_LEN : PH_BID_BLEN;
            else begin
              bib_d = '0; ph_d = (ph == PH_BID_SKIP) ? PH_BID_PX : PH_ASK_PX;
            end
          end
        end else if (ph == PH_TRD_SKIP) begin
          if (bib_d >= gel_q) ph_d = PH_EXEC_LEN;
        end else if (ph == PH_EXEC_CHARS) begin
          r[0] = '{TAG_EXEC_CHAR, 64'(in_i.data_byte), eix_q, kind_q, ERR_NONE, 1'b0};
          n = 2'd1;
          sbl_d = sbl_q - 8'd1;
          if (sbl_d == 8'd0) begin
            eix_d = eixn;
            if (eixn == gec_q) ph_d = PH_SYM_LEN; else begin bib_d = '0; ph_d = PH_FILL; end
          end
        end else if (ph == PH_SYM_CHARS) begin
          r[0] = '{TAG_SYM_CHAR, 64'(in_i.data_byte), 16'd0, kind_q, ERR_NONE, 1'b0};
          n = 2'd1;
          sbl_d = sbl_q - 8'd1;
          if (sbl_d == 8'd0) begin
            r[1] = '{TAG_END, 64'd0, 16'd0, kind_q, ERR_NONE, 1'b0};
            n = 2'd2; ph_d = PH_DONE;
          end
        end else if (!done) begin
          acc_d = accn; bif_d = bifn;
        end else begin
          v = accn; acc_d = '0; bif_d = '0;
          if (ph <= PH_H_VER) begin
            r[0] = '{ph, v, 16'd0, KIND_NONE, ERR_NONE, 1'b0};
            n = 2'd1;
            if (ph == PH_H_BL) rbl_d = v[15:0];
            if (ph == PH_H_TID) begin
              k = (v[15:0] == cfg_i.best_quote) ? KIND_QUOTE :
                  (v[15:0] == cfg_i.book) ? KIND_BOOK :
                  (v[15:0] == cfg_i.trade) ? KIND_TRADE : KIND_NONE;
              kind_d = k;
            end
            known = (kind_q == KIND_QUOTE) ? BestQuoteKnownBlock :
                    (kind_q == KIND_BOOK) ? BookKnownBlock : TradeKnownBlock;
            if (ph < PH_H_VER) ph_d = ph + 6'd1;
            else if (kind_q == KIND_NONE) begin
              r[1] = '{TAG_ERROR, 64'd0, 16'd0, KIND_NONE, ERR_TEMPLATE, 1'b0};
              n = 2'd2; err = 1'b1;
            end else if (rbl_q < known) begin
              r[1] = '{TAG_ERROR, 64'd0, 16'd0, kind_q, ERR_SHORT, 1'b0};
              n = 2'd2; err = 1'b1;
            end else begin
              bib_d = '0; ph_d = PH_BODY_FIRST;
            end
          end else if (ph <= PH_RPI) begin
            val = v;
            if (ph == PH_PEXP || ph == PH_SEXP) val = {{56{v[7]}}, v[7:0]};
            else if (ph == PH_BLOCK_FLAG || ph == PH_RPI) val = {63'd0, v == 64'd1};
            r[0] = '{ph, val, (ph >= PH_ASK_PX) ? eix_q : 16'd0, kind_q, ERR_NONE, 1'b0};
            n = 2'd1;
            if (ph <= PH_PKG) begin
              done = 1'b0;
              if (kind_q == KIND_QUOTE) begin
                if (ph < PH_SEXP) ph_d = ph + 6'd1; else done = 1'b1;
              end else if (kind_q == KIND_BOOK) begin
                if (ph < PH_UPD || ph == PH_PEXP || ph == PH_SEXP) ph_d = ph + 6'd1;
                else if (ph == PH_UPD) ph_d = PH_PEXP;
                else done = 1'b1;
              end else begin
                if (ph == PH_BODY_FIRST) ph_d = PH_PEXP;
                else if (ph == PH_PEXP) ph_d = PH_SEXP;
                else done = 1'b1;
              end
              if (done) begin
                if (bib_d < rbl_q) ph_d = PH_ROOT_SKIP;
                else ph_d = (kind_q == KIND_QUOTE) ? PH_SYM_LEN :
                            (kind_q == KIND_BOOK) ? PH_ASK_BLEN : PH_TRD_BLEN;
              end
            end else if (ph == PH_ASK_SZ || ph == PH_BID_SZ) begin
              if (bib_d < gel_q) ph_d = (ph == PH_ASK_SZ) ? PH_ASK_SKIP : PH_BID_SKIP;
              else begin
                eix_d = eixn;
                if (eixn == gec_q) ph_d = (ph == PH_BID_SZ) ? PH_SYM_LEN : PH_BID_BLEN;
                else begin
                  bib_d = '0; ph_d = (ph == PH_BID_SZ) ? PH_BID_PX : PH_ASK_PX;
                end
              end
            end else if (ph == PH_RPI) begin
              ph_d = (bib_d < gel_q) ? PH_TRD_SKIP : PH_EXEC_LEN;
            end else ph_d = ph + 6'd1;
          end else begin
            unique case (ph)
              PH_ASK_BLEN, PH_BID_BLEN, PH_TRD_BLEN: begin
                gel_d = v[15:0]; ph_d = ph + 6'd1;
              end
              PH_ASK_CNT, PH_BID_CNT, PH_TRD_CNT: begin
                gec_d = v[15:0];
                r[0] = '{(ph == PH_ASK_CNT) ? TAG_ASK_COUNT :
                         (ph == PH_BID_CNT) ? TAG_BID_COUNT : TAG_TRADE_COUNT,
                         v, 16'd0, kind_q, ERR_NONE, 1'b0};
                n = 2'd1;
                known = (ph == PH_TRD_CNT) ? TradeEntryKnownBlock : LevelKnownBlock;
                if (gel_q < known) begin
                  r[1] = '{TAG_ERROR, 64'd0, 16'd0, kind_q, ERR_SHORT, 1'b0};
                  n = 2'd2; err = 1'b1;
                end else begin
                  eix_d = '0;
                  if (v[15:0] == 16'd0) ph_d = (ph == PH_ASK_CNT) ? PH_BID_BLEN : PH_SYM_LEN;
                  else begin
                    bib_d = '0;
                    ph_d = (ph == PH_ASK_CNT) ? PH_ASK_PX :
                           (ph == PH_BID_CNT) ? PH_BID_PX : PH_FILL;
                  end
                end
              end
              PH_EXEC_LEN: begin
                sbl_d = v[7:0];
                if (v[7:0] == 8'd0) begin
                  eix_d = eixn;
                  if (eixn == gec_q) ph_d = PH_SYM_LEN;
                  else begin bib_d = '0; ph_d = PH_FILL; end
                end else ph_d = PH_EXEC_CHARS;
              end
              default: begin
                sbl_d = v[7:0];
                if (v[7:0] == 8'd0) begin
                  r[0] = '{TAG_END, 64'd0, 16'd0, kind_q, ERR_NONE, 1'b0};
                  n = 2'd1; ph_d = PH_DONE;
                end else ph_d = PH_SYM_CHARS;
              end
            endcase
          end
        end
      end
      if (in_i.end_of_payload) begin
        if (!disc_q && !err && ph_d != PH_DONE) begin
          r[n[0]] = '{TAG_ERROR, 64'd0, 16'd0, kind_d, ERR_TRUNC, 1'b0};
          n = n + 2'd1;
        end
        ph_d = PH_H_BL; acc_d = '0; bif_d = '0; rbl_d = '0; kind_d = KIND_NONE;
        gel_d = '0; gec_d = '0; eix_d = '0; bib_d = '0; sbl_d = '0; disc_d = 1'b0;
      end else if (err) begin
        disc_d = 1'b1;
      end
    end
    if (n == 2'd2) r[1].last_of_run = 1'b1;
    else r[0].last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_H_BL; acc_q <= '0; bif_q <= '0; rbl_q <= '0; kind_q <= KIND_NONE;
      gel_q <= '0; gec_q <= '0; eix_q <= '0; bib_q <= '0; sbl_q <= '0; disc_q <= 1'b0;
      pair_valid_o <= 1'b0;
    end else begin
      ph_q <= ph_d; acc_q <= acc_d; bif_q <= bif_d; rbl_q <= rbl_d; kind_q <= kind_d;
      gel_q <= gel_d; gec_q <= gec_d; eix_q <= eix_d; bib_q <= bib_d; sbl_q <= sbl_d;
      disc_q <= disc_d;
      pair_valid_o <= valid_i && (n != 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    pair_o <= '{n == 2'd2, r[0], r[1]};
  end

endmodule
`default_nettype wire

// ===== design/sbe_out_queue.sv =====
// Back part: queue of result pairs, drained one result per pop.
// Depends on sbe_pkg.
`default_nettype none
module sbe_out_queue import sbe_pkg::*; #(
  parameter int unsigned Depth = DefaultQueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire sbe_pair_t pair_i,
  output logic           almost_full_o,
  output logic           empty_o,
  output sbe_out_t       data_o,
  input  wire logic      pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sbe_pair_t mem_q [Depth];
  logic [AW-1:0] rd_q, wr_q;
  logic [AW:0]   cnt_q;
  logic          half_q;
  logic          take;

  assign empty_o = (cnt_q == '0);
  // The parser has a registered result in flight, so keep two slots of slack.
  assign almost_full_o = (cnt_q >= (AW+1)'(Depth - 2));
  assign data_o = half_q ? mem_q[rd_q].second : mem_q[rd_q].first;
  assign take = pop_i && !empty_o && (half_q || !mem_q[rd_q].two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0; half_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i && !empty_o) half_q <= !take;
      if (take) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= pair_i;
  end

endmodule
`default_nettype wire

// ===== design/sbe_market_message_decoder.sv =====
// Top level of the market message decoder: configuration registers, parser, result queue.
// Depends on sbe_pkg, sbe_parser and sbe_out_queue.
`default_nettype none
// Accepts one payload byte per cycle; each byte yields zero, one or two results, which pass
// through the parser register and the result queue. Input stalls only when the result queue
// is near full, so the sustained rate is set by how fast results are popped: one result per
// pop, a pair of results taking two pops.
module sbe_market_message_decoder import sbe_pkg::*; #(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire sbe_in_t            in_i,
  output logic                    empty,
  input  wire logic               pop,
  output sbe_out_t                out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);

  sbe_cfg_t  cfg_q;
  logic      pv;
  sbe_pair_t pair;
  logic      afull;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{BestQuoteTidReset, BookTidReset, TradeTidReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BEST_QUOTE: cfg_q.best_quote <= cfg_data_i;
        CFG_BOOK:       cfg_q.book <= cfg_data_i;
        CFG_TRADE:      cfg_q.trade <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = afull;

  sbe_parser u_parser (
    .clk_i, .rst_ni, .valid_i(push && !full), .in_i, .cfg_i(cfg_q),
    .pair_valid_o(pv), .pair_o(pair)
  );

  sbe_out_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(pv), .pair_i(pair), .almost_full_o(afull),
    .empty_o(empty), .data_o(out_o), .pop_i(pop)
  );

endmodule
`default_nettype wire

// ===== sim/sbe_checker.sv =====
// Checker for the market message decoder: watches the byte and result queues,
// predicts the decoded fields and compares them. Depends on sbe_pkg.
`timescale 1ns / 1ps
module sbe_checker import sbe_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire logic               full,
  input  wire sbe_in_t            in_i,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire sbe_out_t           out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam logic [5:0] PhSide = PH_BLOCK_FLAG - 6'd1;
  localparam logic [5:0] PhTradeSeq = PH_BLOCK_FLAG - 6'd2;

  logic [15:0] tid_quote, tid_book, tid_trade;

  logic [5:0]  phase;
  logic [63:0] acc;
  logic [2:0]  byte_idx;
  logic [15:0] root_len;
  logic [1:0]  kind;
  logic [15:0] grp_len;
  logic [15:0] grp_cnt;
  logic [15:0] entry;
  logic [15:0] blk_bytes;
  logic [7:0]  str_left;
  logic        discard;

  sbe_out_t step_res[2];
  int       step_n;
  sbe_out_t decoded_q[$];

  task automatic note(input logic [5:0] tag, input logic [63:0] v, input logic [15:0] e,
                      input logic [1:0] k, input logic [1:0] er);
    if (step_n < 2) begin
      step_res[step_n].field_tag    = tag;
      step_res[step_n].field_value  = v;
      step_res[step_n].entry_number = e;
      step_res[step_n].message_kind = k;
      step_res[step_n].error_code   = er;
      step_res[step_n].last_of_run  = 1'b0;
      step_n++;
    end
  endtask

  task automatic clear_parser();
    phase = PH_H_BL;
    acc = '0;
    byte_idx = '0;
    root_len = '0;
    kind = KIND_NONE;
    grp_len = '0;
    grp_cnt = '0;
    entry = '0;
    blk_bytes = '0;
    str_left = '0;
    discard = 1'b0;
  endtask

  function automatic int field_bytes(input logic [5:0] ph);
    if (ph <= PH_H_VER) return 2;
    if (ph >= PH_PEXP && ph <= PH_PKG) return 1;
    if (ph >= PhSide && ph <= PH_RPI) return 1;
    if (ph >= PH_BODY_FIRST && ph <= PhTradeSeq) return 8;
    if (ph >= PH_ASK_BLEN && ph <= PH_TRD_CNT) return 2;
    return 1;
  endfunction

  function automatic bit in_block(input logic [5:0] ph);
    return (ph >= PH_BODY_FIRST && ph <= PH_RPI) || ph == PH_ROOT_SKIP ||
           (ph >= PH_ASK_SKIP && ph <= PH_TRD_SKIP);
  endfunction

  function automatic logic [15:0] known_root(input logic [1:0] k);
    case (k)
      KIND_QUOTE: return BestQuoteKnownBlock;
      KIND_BOOK:  return BookKnownBlock;
      KIND_TRADE: return TradeKnownBlock;
      default:    return 16'd0;
    endcase
  endfunction

  task automatic group_begin(input logic [5:0] first, input logic [5:0] when_empty);
    entry = '0;
    if (grp_cnt == 0) begin
      phase = when_empty;
    end else begin
      blk_bytes = '0;
      phase = first;
    end
  endtask

  task automatic root_end();
    if (blk_bytes < root_len) phase = PH_ROOT_SKIP;
    else if (kind == KIND_QUOTE) phase = PH_SYM_LEN;
    else if (kind == KIND_BOOK) phase = PH_ASK_BLEN;
    else phase = PH_TRD_BLEN;
  endtask

  task automatic level_done(input bit bid);
    entry = entry + 16'd1;
    if (entry == grp_cnt) begin
      phase = bid ? PH_SYM_LEN : PH_BID_BLEN;
    end else begin
      blk_bytes = '0;
      phase = bid ? PH_BID_PX : PH_ASK_PX;
    end
  endtask

  task automatic trade_done();
    entry = entry + 16'd1;
    if (entry == grp_cnt) begin
      phase = PH_SYM_LEN;
    end else begin
      blk_bytes = '0;
      phase = PH_FILL;
    end
  endtask

  task automatic root_next(input logic [5:0] ph);
    if (kind == KIND_QUOTE) begin
      if (ph < PH_SEXP) phase = ph + 6'd1;
      else root_end();
    end else if (kind == KIND_BOOK) begin
      if (ph < PH_UPD || ph == PH_PEXP || ph == PH_SEXP) phase = ph + 6'd1;
      else if (ph == PH_UPD) phase = PH_PEXP;
      else root_end();
    end else begin
      if (ph == PH_BODY_FIRST) phase = PH_PEXP;
      else if (ph == PH_PEXP) phase = PH_SEXP;
      else root_end();
    end
  endtask

  task automatic finish_field(input logic [5:0] ph, input logic [63:0] v, output bit err);
    logic [63:0] val;
    err = 1'b0;
    val = v;
    if (ph <= PH_H_VER) begin
      note(ph, v, '0, KIND_NONE, ERR_NONE);
      if (ph == PH_H_BL) root_len = v[15:0];
      if (ph == PH_H_TID) begin
        // Equal registers resolve in favor of the quote, then the book.
        kind = (v[15:0] == tid_quote) ? KIND_QUOTE : (v[15:0] == tid_book) ? KIND_BOOK :
               (v[15:0] == tid_trade) ? KIND_TRADE : KIND_NONE;
      end
      if (ph < PH_H_VER) begin
        phase = ph + 6'd1;
        return;
      end
      if (kind == KIND_NONE) begin
        note(TAG_ERROR, '0, '0, KIND_NONE, ERR_TEMPLATE);
        err = 1'b1;
        return;
      end
      if (root_len < known_root(kind)) begin
        note(TAG_ERROR, '0, '0, kind, ERR_SHORT);
        err = 1'b1;
        return;
      end
      blk_bytes = '0;
      phase = PH_BODY_FIRST;
      return;
    end
    if (ph <= PH_RPI) begin
      if (ph == PH_PEXP || ph == PH_SEXP) val = {{56{v[7]}}, v[7:0]};
      else if (ph == PH_BLOCK_FLAG || ph == PH_RPI) val = (v == 64'd1) ? 64'd1 : 64'd0;
      note(ph, val, (ph >= PH_ASK_PX) ? entry : 16'd0, kind, ERR_NONE);
      if (ph <= PH_PKG) begin
        root_next(ph);
      end else if (ph == PH_ASK_PX || ph == PH_BID_PX ||
                   (ph >= PH_FILL && ph <= PH_BLOCK_FLAG)) begin
        phase = ph + 6'd1;
      end else if (ph == PH_ASK_SZ || ph == PH_BID_SZ) begin
        if (blk_bytes < grp_len) phase = (ph == PH_ASK_SZ) ? PH_ASK_SKIP : PH_BID_SKIP;
        else level_done(ph == PH_BID_SZ);
      end else begin
        phase = (blk_bytes < grp_len) ? PH_TRD_SKIP : PH_EXEC_LEN;
      end
      return;
    end
    case (ph)
      PH_ASK_BLEN, PH_BID_BLEN, PH_TRD_BLEN: begin
        grp_len = v[15:0];
        phase = ph + 6'd1;
      end
      PH_ASK_CNT, PH_BID_CNT, PH_TRD_CNT: begin
        grp_cnt = v[15:0];
        note((ph == PH_ASK_CNT) ? TAG_ASK_COUNT : (ph == PH_BID_CNT) ? TAG_BID_COUNT :
             TAG_TRADE_COUNT, v, '0, kind, ERR_NONE);
        if (grp_len < ((ph == PH_TRD_CNT) ? TradeEntryKnownBlock : LevelKnownBlock)) begin
          note(TAG_ERROR, '0, '0, kind, ERR_SHORT);
          err = 1'b1;
        end else if (ph == PH_ASK_CNT) begin
          group_begin(PH_ASK_PX, PH_BID_BLEN);
        end else if (ph == PH_BID_CNT) begin
          group_begin(PH_BID_PX, PH_SYM_LEN);
        end else begin
          group_begin(PH_FILL, PH_SYM_LEN);
        end
      end
      PH_EXEC_LEN: begin
        str_left = v[7:0];
        if (v == 0) trade_done();
        else phase = PH_EXEC_CHARS;
      end
      default: begin
        str_left = v[7:0];
        if (v == 0) begin
          note(TAG_END, '0, '0, kind, ERR_NONE);
          phase = PH_DONE;
        end else begin
          phase = PH_SYM_CHARS;
        end
      end
    endcase
  endtask

  task automatic consume(input logic [7:0] b, output bit err);
    logic [5:0]  ph;
    logic [63:0] v;
    err = 1'b0;
    ph = phase;
    if (in_block(ph)) blk_bytes = blk_bytes + 16'd1;
    if (ph == PH_ROOT_SKIP) begin
      if (blk_bytes >= root_len) root_end();
      return;
    end
    if (ph == PH_ASK_SKIP || ph == PH_BID_SKIP) begin
      if (blk_bytes >= grp_len) level_done(ph == PH_BID_SKIP);
      return;
    end
    if (ph == PH_TRD_SKIP) begin
      if (blk_bytes >= grp_len) phase = PH_EXEC_LEN;
      return;
    end
    if (ph == PH_EXEC_CHARS) begin
      note(TAG_EXEC_CHAR, {56'd0, b}, entry, kind, ERR_NONE);
      str_left = str_left - 8'd1;
      if (str_left == 0) trade_done();
      return;
    end
    if (ph == PH_SYM_CHARS) begin
      note(TAG_SYM_CHAR, {56'd0, b}, '0, kind, ERR_NONE);
      str_left = str_left - 8'd1;
      if (str_left == 0) begin
        note(TAG_END, '0, '0, kind, ERR_NONE);
        phase = PH_DONE;
      end
      return;
    end
    acc = acc | ({56'd0, b} << (8 * byte_idx));
    byte_idx = byte_idx + 3'd1;
    if (byte_idx != 0 && byte_idx < field_bytes(ph)) return;
    v = acc;
    acc = '0;
    byte_idx = '0;
    finish_field(ph, v, err);
  endtask

  task automatic decode_byte(input sbe_in_t x);
    bit err;
    step_n = 0;
    err = 1'b0;
    if (!discard && phase != PH_DONE) consume(x.data_byte, err);
    if (x.end_of_payload) begin
      if (!discard && !err && phase != PH_DONE) note(TAG_ERROR, '0, '0, kind, ERR_TRUNC);
      clear_parser();
    end else if (err) begin
      discard = 1'b1;
    end
    if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors_o++;
    end
  endtask

  // Inputs are driven at the rising edge, so the falling edge sees what the next
  // rising edge will accept.
  always @(negedge clk_i) begin
    sbe_out_t want;
    if (!rst_ni) begin
      tid_quote = BestQuoteTidReset;
      tid_book = BookTidReset;
      tid_trade = TradeTidReset;
      clear_parser();
      decoded_q.delete();
    end else begin
      // A byte accepted at the same edge as a write still sees the old template ids.
      if (push && !full) decode_byte(in_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BEST_QUOTE: tid_quote = cfg_data_i;
          CFG_BOOK:       tid_book = cfg_data_i;
          CFG_TRADE:      tid_trade = cfg_data_i;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        checked_o++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_o);
          errors_o++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("field_tag", 64'(want.field_tag), 64'(out_o.field_tag));
          compare_field("field_value", want.field_value, out_o.field_value);
          compare_field("entry_number", 64'(want.entry_number), 64'(out_o.entry_number));
          compare_field("message_kind", 64'(want.message_kind), 64'(out_o.message_kind));
          compare_field("error_code", 64'(want.error_code), 64'(out_o.error_code));
          compare_field("last_of_run", 64'(want.last_of_run), 64'(out_o.last_of_run));
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the market message decoder: clock, reset, payload stimulus,
// template id settings and verdict. Depends on sbe_pkg, sbe_checker and sbe_market_message_decoder.
`timescale 1ns / 1ps
module tb;
  import sbe_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseCount = 6;
  localparam int BytesPerPhase = 320;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  sbe_in_t            in_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  sbe_out_t           out_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;

  int errors, pending, checked;
  int cycles = 0;
  int messages = 0;
  int bytes_sent = 0;
  int pop_stall = 0;
  bit quiet = 1'b0;

  logic [15:0] tid_quote = BestQuoteTidReset;
  logic [15:0] tid_book = BookTidReset;
  logic [15:0] tid_trade = TradeTidReset;
  logic [7:0]  payload_q[$];

  sbe_market_message_decoder i_dut (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  sbe_checker i_checker (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts except in the final phase.
  always @(posedge clk_i) begin
    if (quiet) begin
      pop <= 1'b1;
    end else if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_stall <= $urandom_range(0, 6);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    bit took;
    push <= 1'b1;
    in_i <= {b, last};
    do begin
      @(negedge clk_i);
      took = !full;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_payload();
    for (int i = 0; i < payload_q.size(); i++) send_byte(payload_q[i], i == payload_q.size() - 1);
    messages++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    payload_q.insert(payload_q.size(), b);
  endtask

  task automatic put16(input logic [15:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
  endtask

  task automatic put_random(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] flag_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      3:       return 8'($urandom_range(0, 255));
      default: return 8'd1;
    endcase
  endfunction

  // One repeating group; ok is low when a short entry length ends the message.
  task automatic put_group(input int known, input bit trades, output bit ok);
    int elen, cnt, start, slen;
    ok = 1'b1;
    if ($urandom_range(0, 14) == 0) begin
      elen = $urandom_range(0, known - 1);
      ok = 1'b0;
    end else begin
      elen = known + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
    end
    cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    put16(16'(elen));
    put16(16'(cnt));
    if (!ok) return;
    for (int i = 0; i < cnt; i++) begin
      start = payload_q.size();
      put_random(elen);
      if (trades) begin
        payload_q[start + 33] = flag_byte();
        payload_q[start + 34] = flag_byte();
        slen = $urandom_range(0, 3);
        add_byte(8'(slen));
        put_random(slen);
      end
    end
  endtask

  task automatic build_message();
    int kind_sel, known, bl, cut;
    bit short_root, ok;
    logic [15:0] tid;
    payload_q.delete();
    if ($urandom_range(0, 99) < 3) begin
      put_random($urandom_range(1, 12));
      return;
    end
    kind_sel = ($urandom_range(0, 16) == 0) ? 0 : $urandom_range(1, 3);
    case (kind_sel)
      1: begin tid = tid_quote; known = int'(BestQuoteKnownBlock); end
      2: begin tid = tid_book; known = int'(BookKnownBlock); end
      3: begin tid = tid_trade; known = int'(TradeKnownBlock); end
      default: begin
        known = 0;
        do tid = 16'($urandom_range(0, 65535));
        while (tid == tid_quote || tid == tid_book || tid == tid_trade);
      end
    endcase
    short_root = kind_sel != 0 && $urandom_range(0, 19) == 0;
    if (short_root) bl = $urandom_range(0, known - 1);
    else bl = known + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
    put16(16'(bl));
    put16(tid);
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    if (kind_sel == 0 || short_root) begin
      put_random($urandom_range(0, 3));
      return;
    end
    put_random(bl);
    ok = 1'b1;
    if (kind_sel == 2) begin
      put_group(int'(LevelKnownBlock), 1'b0, ok);
      if (ok) put_group(int'(LevelKnownBlock), 1'b0, ok);
    end else if (kind_sel == 3) begin
      put_group(int'(TradeEntryKnownBlock), 1'b1, ok);
    end
    if (!ok) return;
    cut = $urandom_range(0, 6);
    add_byte(8'(cut));
    put_random(cut);
    if ($urandom_range(0, 6) == 0) put_random($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, payload_q.size() - 1);
      while (payload_q.size() > cut) void'(payload_q.pop_back());
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // Bytes that cause no result may still be in flight.
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_ids(input logic [15:0] q, input logic [15:0] b, input logic [15:0] t);
    tid_quote = q;
    tid_book = b;
    tid_trade = t;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_BEST_QUOTE;
    cfg_data_i <= q;
    @(posedge clk_i);
    cfg_idx_i <= CFG_BOOK;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_idx_i <= CFG_TRADE;
    cfg_data_i <= t;
    @(posedge clk_i);
    // The unused index must leave the template ids alone.
    cfg_idx_i <= CfgIdxUnused;
    cfg_data_i <= 16'($urandom_range(0, 65535));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int phase_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unknown template, a lone final byte, a root block that is too short.
    payload_q.delete();
    put16(16'd0);
    put16(16'd1);
    put16(16'hFFFF);
    put16(16'd0);
    send_payload();
    payload_q.delete();
    add_byte(8'hFF);
    send_payload();
    payload_q.delete();
    put16(16'd0);
    put16(BestQuoteTidReset);
    put16(16'd1);
    put16(16'd1);
    send_payload();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1: write_ids(16'd0, 16'd1, 16'd2);
          2: write_ids(16'hFFFF, 16'hFFFF, 16'hFFFF);
          3: write_ids(16'd100, 16'd7, 16'd7);
          4: write_ids(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
          default: begin
            write_ids(BestQuoteTidReset, BookTidReset, TradeTidReset);
            quiet = 1'b1;
          end
        endcase
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerPhase) begin
        build_message();
        send_payload();
      end
    end

    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d payloads (%0d bytes) over %0d template id settings.",
             messages, bytes_sent, PhaseCount);
    $display("Checked %0d decoded results.", checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sbe_pkg.sv
design/sbe_parser.sv
design/sbe_out_queue.sv
design/sbe_market_message_decoder.sv
sim/sbe_checker.sv
sim/tb.sv
